// ===== src/tonh_pkg.sv =====
// Shared types, codes and constants of the tree overlay next-hop unit.
`default_nettype none

package tonh_pkg;

	// Width of the destination and next-hop fields.
	localparam int unsigned HOP_BITS = 16;
	// Width of the fan-out register.
	localparam int unsigned FANOUT_BITS = 16;
	// Width of the step counter of the serial divider.
	localparam int unsigned DIV_CNT_BITS = $clog2(HOP_BITS);
	// Default rank width.
	localparam int unsigned RANK_BITS_DEF = 16;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TREE_SHAPE = 2'd0;
	localparam logic [1:0] CFG_FANOUT_K   = 2'd1;
	localparam logic [1:0] CFG_NODE_COUNT = 2'd2;
	localparam logic [1:0] CFG_SELF_RANK  = 2'd3;

	// Tree shapes.
	localparam logic [1:0] SHAPE_FLAT     = 2'd0;
	localparam logic [1:0] SHAPE_KARY     = 2'd1;
	localparam logic [1:0] SHAPE_MINCRIT  = 2'd2;
	localparam logic [1:0] SHAPE_BINOMIAL = 2'd3;

	// Route status codes.
	localparam logic [1:0] STATUS_ROUTED    = 2'd0;
	localparam logic [1:0] STATUS_INVALID   = 2'd1;
	localparam logic [1:0] STATUS_NOT_BELOW = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [1:0]             SHAPE_RESET  = SHAPE_FLAT;
	localparam logic [FANOUT_BITS-1:0] FANOUT_RESET = FANOUT_BITS'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIVIDE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== src/tree_overlay_next_hop_unit.sv =====
// Top level of the tree overlay next-hop unit: registers, walk sequencer and output stage.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid / in_stall  dest_rank
//   out      source     out_valid / out_stall next_hop, route_status
//   config   sink       wr_en                wr_index, wr_data
//
// An accepted item is registered. Each level of the walk takes its parent directly for
// the flat and binomial shapes; for the k-ary and mincrit shapes each parent comes from the
// shared serial divider (one quotient bit per cycle). The walk stops when the parent is
// self_rank or the current rank is not above self_rank; the result then moves into the
// output register. Reset restores the configuration defaults, clears out_valid and leaves
// the block idle. A result held by out_stall does not block the next transfer on the input
// side; only the following result waits for the output register to free up.
`default_nettype none

module tree_overlay_next_hop_unit #(
	parameter int unsigned RANK_BITS = tonh_pkg::RANK_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,

	input  wire logic                                  wr_en,
	input  wire logic [1:0]                            wr_index,
	input  wire logic [((RANK_BITS + 1) > tonh_pkg::FANOUT_BITS ?
		(RANK_BITS + 1) : tonh_pkg::FANOUT_BITS)-1:0] wr_data,

	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [tonh_pkg::HOP_BITS-1:0]          dest_rank,

	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic      [tonh_pkg::HOP_BITS-1:0]          next_hop,
	output logic      [1:0]                            route_status
);

	localparam int unsigned HopBits = tonh_pkg::HOP_BITS;
	localparam int unsigned CntBits = RANK_BITS + 1;
	localparam int unsigned CmpBits = (RANK_BITS > HopBits) ? RANK_BITS : HopBits;
	localparam int unsigned LimBits = (CntBits > HopBits) ? CntBits : HopBits;

	// Configuration registers.
	logic [1:0]                        shape_q;
	logic [tonh_pkg::FANOUT_BITS-1:0]  fanout_q;
	logic [CntBits-1:0]                count_q;
	logic [RANK_BITS-1:0]              self_q;

	tonh_pkg::state_t state_q;
	tonh_pkg::state_t state_d;

	logic [HopBits-1:0] rank_q;
	logic [HopBits-1:0] hop_q;
	logic [1:0]         status_q;

	logic               out_valid_q;
	logic [HopBits-1:0] next_hop_q;
	logic [1:0]         route_status_q;

	logic               div_start;
	logic               div_done;
	logic [HopBits-1:0] div_num;
	logic [HopBits-1:0] div_quot;
	logic [HopBits-1:0] div_rem;

	logic               accept;
	logic               dest_invalid;
	logic               k_zero;
	logic               walk_kary;
	logic               walk_mincrit;
	logic               need_div;
	logic               early_exit;
	logic [HopBits-1:0] direct_parent;
	logic [HopBits-1:0] parent;
	logic               parent_ready;
	logic               hit;
	logic               slot_free;
	logic               load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= tonh_pkg::SHAPE_RESET;
			fanout_q <= tonh_pkg::FANOUT_RESET;
			count_q  <= CntBits'(1);
			self_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				tonh_pkg::CFG_TREE_SHAPE: shape_q  <= wr_data[1:0];
				tonh_pkg::CFG_FANOUT_K:   fanout_q <= wr_data[tonh_pkg::FANOUT_BITS-1:0];
				tonh_pkg::CFG_NODE_COUNT: count_q  <= wr_data[CntBits-1:0];
				tonh_pkg::CFG_SELF_RANK:  self_q   <= wr_data[RANK_BITS-1:0];
			endcase
		end
	end

	// Decisions for the current rank of the walk.
	always_comb begin
		accept       = in_valid && !in_stall;
		dest_invalid = (dest_rank == '0) || (LimBits'(dest_rank) >= LimBits'(count_q));
		k_zero       = (fanout_q == '0);
		walk_kary    = (shape_q == tonh_pkg::SHAPE_KARY) && !k_zero;
		walk_mincrit = (shape_q == tonh_pkg::SHAPE_MINCRIT) && !k_zero && (rank_q > fanout_q);
		need_div     = walk_kary || walk_mincrit;
		// Parents strictly decrease, so once the rank is not above self it cannot be met.
		early_exit   = (rank_q == '0) || (CmpBits'(rank_q) <= CmpBits'(self_q));
		direct_parent = (shape_q == tonh_pkg::SHAPE_BINOMIAL) ?
			(rank_q & (rank_q - 1'b1)) : '0;
		div_num = walk_kary ? (rank_q - 1'b1) : (rank_q - fanout_q - 1'b1);
		if (state_q == tonh_pkg::ST_DIVIDE) begin
			parent       = walk_kary ? div_quot : (div_rem + 1'b1);
			parent_ready = div_done;
		end else begin
			parent       = direct_parent;
			parent_ready = (state_q == tonh_pkg::ST_WALK) && !early_exit && !need_div;
		end
		hit       = parent_ready && (CmpBits'(parent) == CmpBits'(self_q));
		slot_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tonh_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = dest_invalid ? tonh_pkg::ST_DONE : tonh_pkg::ST_WALK;
				end
			end
			tonh_pkg::ST_WALK: begin
				priority if (early_exit) begin
					state_d = tonh_pkg::ST_DONE;
				end else if (need_div) begin
					state_d = tonh_pkg::ST_DIVIDE;
				end else if (hit) begin
					state_d = tonh_pkg::ST_DONE;
				end else begin
					state_d = tonh_pkg::ST_WALK;
				end
			end
			tonh_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = hit ? tonh_pkg::ST_DONE : tonh_pkg::ST_WALK;
				end
			end
			tonh_pkg::ST_DONE: begin
				if (slot_free) begin
					state_d = tonh_pkg::ST_IDLE;
				end
			end
			default: state_d = tonh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != tonh_pkg::ST_IDLE);
		div_start = (state_q == tonh_pkg::ST_WALK) && !early_exit && need_div;
		load_out  = (state_q == tonh_pkg::ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tonh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rank_q   <= dest_rank;
			hop_q    <= '0;
			status_q <= dest_invalid ? tonh_pkg::STATUS_INVALID : tonh_pkg::STATUS_NOT_BELOW;
		end else if (parent_ready) begin
			if (hit) begin
				hop_q    <= rank_q;
				status_q <= tonh_pkg::STATUS_ROUTED;
			end else begin
				rank_q <= parent;
			end
		end
		if (load_out) begin
			next_hop_q     <= hop_q;
			route_status_q <= status_q;
		end
	end

	tonh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (fanout_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	assign out_valid    = out_valid_q;
	assign next_hop     = next_hop_q;
	assign route_status = route_status_q;

endmodule

`default_nettype wire

// ===== src/tonh_div.sv =====
// Restoring serial divider that yields one quotient bit per cycle.
`default_nettype none

module tonh_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [tonh_pkg::HOP_BITS-1:0] num,
	input  wire logic [tonh_pkg::HOP_BITS-1:0] den,
	output logic                              done,
	output logic      [tonh_pkg::HOP_BITS-1:0] quot,
	output logic      [tonh_pkg::HOP_BITS-1:0] rem
);

	localparam int unsigned Bits = tonh_pkg::HOP_BITS;
	localparam logic [tonh_pkg::DIV_CNT_BITS-1:0] LastStep =
		tonh_pkg::DIV_CNT_BITS'(Bits - 1);

	logic [Bits-1:0]                     num_q;
	logic [Bits-1:0]                     den_q;
	logic [Bits-1:0]                     rem_q;
	logic [tonh_pkg::DIV_CNT_BITS-1:0]   cnt_q;
	logic                                busy_q;
	logic                                done_q;

	logic [Bits:0] trial;
	logic [Bits:0] diff;
	logic          fits;

	// The partial remainder takes the next numerator bit; the divisor is subtracted when it fits.
	always_comb begin
		trial = {rem_q, num_q[Bits-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[Bits-2:0], fits};
			rem_q <= fits ? diff[Bits-1:0] : trial[Bits-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire
